// ===== design/rate_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rate_pkg: shared types and codes of the ranked array store
// Operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package rate_pkg;

	typedef enum logic [2:0] {
		OP_READ     = 3'd0,
		OP_INSERT   = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_FIND     = 3'd3,
		OP_SEARCH   = 3'd4,
		OP_INVCOUNT = 3'd5,
		OP_COLLAPSE = 3'd6,
		OP_BAD      = 3'd7
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ_WAIT,
		S_INS_RD,
		S_INS_WR,
		S_REM_RD,
		S_REM_WR,
		S_FIND_RD,
		S_FIND_CMP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_INV_RD,
		S_INV_CMP,
		S_COL_RD,
		S_COL_CMP,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== design/rank_array_table_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rank_array_table_engine: ranked array store over one memory
// Read, insert, range remove, find, binary search, inversion count, collapse.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | operation, rank_low, rank_high, key_value
// m_axis  | out | status, found_rank, element_out, tally, count_after
//
// One item at a time. Read waits in S_READ_WAIT for the registered memory
// data; binary search halves the rank range at each probe; insert, remove,
// find, inversion count and collapse walk the entries one by one through
// the single memory read port (read, then compare or write).
// Reset clears the count; memory content is kept undefined. A stalled
// result holds; the next word is taken once the result is gone.
// ----------------------------------------------------------------------------
module rank_array_table_engine #(
	parameter int DEPTH        = 256,
	parameter int ELEMENT_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[2:0], rank_low[11:3], rank_high[20:12], key_value[52:21], zero
	input  wire [55:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// status[1:0], found_rank[11:2], element_out[43:12], tally[52:44],
	// count_after[61:53], zero
	output logic [63:0] m_axis_tdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EB = ELEMENT_BITS;

	rate_pkg::state_t state_q, state_d;

	logic [2:0]    op_q;
	logic [CW-1:0] lo_q, hi_q, cnt_q;
	logic [EB-1:0] key_q;
	logic [CW-1:0] i_q, j_q, b_q;
	logic [EB-1:0] prev_q;
	logic [8:0]    tally_q;
	logic [1:0]    status_q;
	logic [9:0]    found_q;
	logic [31:0]   elem_q;
	logic          first_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [EB-1:0] wr_data, rd_data;

	rate_mem #(.DEPTH(DEPTH), .ELEMENT_BITS(EB), .AW(AW)) u_mem (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	// request fields
	logic [2:0]    in_op;
	logic [CW-1:0] in_lo, in_hi;
	logic [EB-1:0] in_key;
	logic          range_ok;
	assign in_op  = s_axis_tdata[2:0];
	assign in_lo  = CW'(s_axis_tdata[11:3]);
	assign in_hi  = CW'(s_axis_tdata[20:12]);
	assign in_key = EB'(s_axis_tdata[52:21]);
	assign range_ok = ({1'b0, s_axis_tdata[11:3]} <= {1'b0, s_axis_tdata[20:12]}) &&
		(32'(s_axis_tdata[20:12]) <= 32'(cnt_q));

	assign s_axis_tready = (state_q == rate_pkg::S_IDLE) && !m_axis_tvalid;

	logic [CW:0]   mid;
	assign mid = ({1'b0, i_q} + {1'b0, b_q}) >> 1;

	// memory port steering
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(i_q);
		wr_data = rd_data;
		rd_addr = AW'(i_q);
		state_d = state_q;
		unique case (state_q)
			// read the target rank while the request is accepted
			rate_pkg::S_IDLE: rd_addr = AW'(in_lo);
			rate_pkg::S_READ_WAIT: state_d = rate_pkg::S_DONE;
			rate_pkg::S_INS_RD: begin
				rd_addr = AW'(i_q - CW'(1));
				if (i_q > lo_q) state_d = rate_pkg::S_INS_WR;
				else begin
					wr_en   = 1'b1;
					wr_addr = AW'(lo_q);
					wr_data = key_q;
					state_d = rate_pkg::S_DONE;
				end
			end
			rate_pkg::S_INS_WR: begin
				wr_en   = 1'b1;
				state_d = rate_pkg::S_INS_RD;
			end
			rate_pkg::S_REM_RD: begin
				rd_addr = AW'(j_q);
				if (j_q < cnt_q) state_d = rate_pkg::S_REM_WR;
				else state_d = rate_pkg::S_DONE;
			end
			rate_pkg::S_REM_WR: begin
				wr_en   = 1'b1;
				state_d = rate_pkg::S_REM_RD;
			end
			rate_pkg::S_FIND_RD: begin
				rd_addr = AW'(i_q - CW'(1));
				if (i_q > lo_q) state_d = rate_pkg::S_FIND_CMP;
				else state_d = rate_pkg::S_DONE;
			end
			rate_pkg::S_FIND_CMP:
				state_d = (rd_data == key_q) ? rate_pkg::S_DONE : rate_pkg::S_FIND_RD;
			rate_pkg::S_SRCH_RD: begin
				rd_addr = AW'(mid);
				if (i_q < b_q) state_d = rate_pkg::S_SRCH_CMP;
				else state_d = rate_pkg::S_DONE;
			end
			rate_pkg::S_SRCH_CMP: state_d = rate_pkg::S_SRCH_RD;
			rate_pkg::S_INV_RD: begin
				rd_addr = AW'(j_q);
				if (j_q < cnt_q) state_d = rate_pkg::S_INV_CMP;
				else state_d = rate_pkg::S_DONE;
			end
			rate_pkg::S_INV_CMP: state_d = rate_pkg::S_INV_RD;
			rate_pkg::S_COL_RD: begin
				rd_addr = AW'(j_q);
				if (j_q < cnt_q) state_d = rate_pkg::S_COL_CMP;
				else state_d = rate_pkg::S_DONE;
			end
			rate_pkg::S_COL_CMP: begin
				// prev holds entry at w (i_q); keep new value
				if (!first_q && rd_data != prev_q) begin
					wr_en   = 1'b1;
					wr_addr = AW'(i_q + CW'(1));
				end
				state_d = rate_pkg::S_COL_RD;
			end
			rate_pkg::S_DONE: state_d = rate_pkg::S_IDLE;
			default: state_d = rate_pkg::S_IDLE;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= rate_pkg::S_IDLE;
			cnt_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			if (state_q == rate_pkg::S_IDLE && s_axis_tvalid && s_axis_tready) begin
				unique case (in_op)
					rate_pkg::OP_READ:
						state_q <= (in_lo < cnt_q) ? rate_pkg::S_READ_WAIT : rate_pkg::S_DONE;
					rate_pkg::OP_INSERT:
						state_q <= (32'(cnt_q) >= DEPTH || in_lo > cnt_q) ?
							rate_pkg::S_DONE : rate_pkg::S_INS_RD;
					rate_pkg::OP_REMOVE:
						state_q <= (range_ok && in_hi > in_lo) ?
							rate_pkg::S_READ_WAIT : rate_pkg::S_DONE;
					rate_pkg::OP_FIND:
						state_q <= range_ok ? rate_pkg::S_FIND_RD : rate_pkg::S_DONE;
					rate_pkg::OP_SEARCH:
						state_q <= range_ok ? rate_pkg::S_SRCH_RD : rate_pkg::S_DONE;
					rate_pkg::OP_INVCOUNT: state_q <= rate_pkg::S_INV_RD;
					rate_pkg::OP_COLLAPSE:
						state_q <= (cnt_q != '0) ? rate_pkg::S_COL_RD : rate_pkg::S_DONE;
					default: state_q <= rate_pkg::S_DONE;
				endcase
			end else if (state_q == rate_pkg::S_READ_WAIT && op_q == rate_pkg::OP_REMOVE) begin
				state_q <= rate_pkg::S_REM_RD;
			end else begin
				state_q <= state_d;
			end
			if (state_q == rate_pkg::S_DONE) begin
				m_axis_tvalid <= 1'b1;
				if (status_q == rate_pkg::ST_OK) begin
					if (op_q == rate_pkg::OP_INSERT) cnt_q <= cnt_q + CW'(1);
					if (op_q == rate_pkg::OP_REMOVE) cnt_q <= cnt_q - (hi_q - lo_q);
					if (op_q == rate_pkg::OP_COLLAPSE && cnt_q != '0) cnt_q <= i_q + CW'(1);
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == rate_pkg::S_IDLE && s_axis_tvalid && s_axis_tready) begin
			op_q     <= in_op;
			lo_q     <= in_lo;
			hi_q     <= in_hi;
			key_q    <= in_key;
			tally_q  <= '0;
			found_q  <= '0;
			elem_q   <= '0;
			first_q  <= 1'b1;
			status_q <= rate_pkg::ST_OK;
			i_q      <= in_lo;
			j_q      <= in_hi;
			b_q      <= in_hi;
			unique case (in_op)
				rate_pkg::OP_READ:
					if (!(in_lo < cnt_q)) status_q <= rate_pkg::ST_RANGE;
				rate_pkg::OP_INSERT: begin
					i_q <= cnt_q;
					if (32'(cnt_q) >= DEPTH) status_q <= rate_pkg::ST_FULL;
					else if (in_lo > cnt_q) status_q <= rate_pkg::ST_RANGE;
				end
				rate_pkg::OP_REMOVE, rate_pkg::OP_SEARCH:
					if (!range_ok) status_q <= rate_pkg::ST_RANGE;
				rate_pkg::OP_FIND: begin
					i_q <= in_hi;
					if (!range_ok) status_q <= rate_pkg::ST_RANGE;
				end
				rate_pkg::OP_INVCOUNT: j_q <= '0;
				rate_pkg::OP_COLLAPSE: begin
					i_q <= '0;
					j_q <= '0;
				end
				default: status_q <= rate_pkg::ST_RANGE;
			endcase
		end else begin
			case (state_q)
				rate_pkg::S_READ_WAIT: elem_q <= 32'(rd_data);
				rate_pkg::S_INS_WR: i_q <= i_q - CW'(1);
				rate_pkg::S_INS_RD:
					if (!(i_q > lo_q)) begin
						found_q <= 10'(lo_q);
						tally_q <= '0;
					end
				rate_pkg::S_REM_RD: tally_q <= 9'(hi_q - lo_q);
				rate_pkg::S_REM_WR: begin
					i_q <= i_q + CW'(1);
					j_q <= j_q + CW'(1);
				end
				rate_pkg::S_FIND_RD:
					if (!(i_q > lo_q)) found_q <= 10'(i_q) - 10'd1;
				rate_pkg::S_FIND_CMP:
					if (rd_data == key_q) found_q <= 10'(i_q) - 10'd1;
					else i_q <= i_q - CW'(1);
				rate_pkg::S_SRCH_RD: begin
					j_q <= CW'(mid);
					if (!(i_q < b_q)) found_q <= 10'(i_q) - 10'd1;
				end
				rate_pkg::S_SRCH_CMP:
					if (key_q < rd_data) b_q <= j_q;
					else i_q <= j_q + CW'(1);
				rate_pkg::S_INV_CMP: begin
					if (!first_q && prev_q > rd_data) tally_q <= tally_q + 9'd1;
					prev_q  <= rd_data;
					first_q <= 1'b0;
					j_q     <= j_q + CW'(1);
				end
				rate_pkg::S_COL_CMP: begin
					if (first_q) prev_q <= rd_data;
					else if (rd_data != prev_q) begin
						prev_q <= rd_data;
						i_q    <= i_q + CW'(1);
					end
					first_q <= 1'b0;
					j_q     <= j_q + CW'(1);
				end
				rate_pkg::S_COL_RD:
					if (!(j_q < cnt_q)) tally_q <= 9'(cnt_q - i_q - CW'(1));
				default: ;
			endcase
		end
	end

	// result word
	logic [8:0] cnt_out;
	always_comb begin
		cnt_out = 9'(cnt_q);
	end
	assign m_axis_tdata = {2'b00, cnt_out, tally_q, elem_q, found_q, status_q};

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= DEPTH) else $error("count above depth");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rate_pkg::S_DONE) |=> m_axis_tvalid) else $error("result lost");

endmodule
`default_nettype wire

// ===== design/rate_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rate_mem: element memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rate_mem #(
	parameter int DEPTH        = 256,
	parameter int ELEMENT_BITS = 32,
	parameter int AW           = 8
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [AW-1:0]            wr_addr,
	input  wire [ELEMENT_BITS-1:0]  wr_data,
	input  wire [AW-1:0]            rd_addr,
	output logic [ELEMENT_BITS-1:0] rd_data
);

	logic [ELEMENT_BITS-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for rank_array_table_engine
// Drives request words (directed table, fill to full and drain, then random
// traffic in idle phases), keeps a shadow copy of the ranked store to predict
// each result word, and compares every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH     = 256;
	localparam int LIMIT     = 3000000;
	localparam int N_RANDOM  = 1000;

	// declared from the top bit down so status lands in the low bits
	typedef struct packed {
		logic [8:0]  count_after;
		logic [8:0]  tally;
		logic [31:0] element_out;
		logic [9:0]  found_rank;
		logic [1:0]  status;
	} result_t;

	typedef struct {
		rate_pkg::op_t op;
		int            lo;
		int            hi;
		logic [31:0]   key;
		logic          has_fixed;
		result_t       fixed;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [63:0] m_axis_tdata;

	// shadow store and pending predictions
	logic [31:0] shadow_store [DEPTH];
	int          shadow_count;
	result_t     pending_results [$];
	int          mismatches;
	int          cycles;
	int          send_gap_pct;
	int          stall_pct;

	rank_array_table_engine uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// predict one result word and update the shadow store
	function automatic result_t predict_store(rate_pkg::op_t op, int lo, int hi,
			logic [31:0] key);
		result_t r;
		int a, b, m, w;
		r = '0;
		case (op)
			rate_pkg::OP_READ: begin
				if (lo < shadow_count) r.element_out = shadow_store[lo];
				else r.status = rate_pkg::ST_RANGE;
			end
			rate_pkg::OP_INSERT: begin
				if (shadow_count >= DEPTH) r.status = rate_pkg::ST_FULL;
				else if (lo > shadow_count) r.status = rate_pkg::ST_RANGE;
				else begin
					for (int i = shadow_count; i > lo; i--) shadow_store[i] = shadow_store[i-1];
					shadow_store[lo] = key;
					shadow_count++;
					r.found_rank = 10'(lo);
				end
			end
			rate_pkg::OP_REMOVE: begin
				if (lo > hi || hi > shadow_count) r.status = rate_pkg::ST_RANGE;
				else if (hi > lo) begin
					r.element_out = shadow_store[lo];
					r.tally = 9'(hi - lo);
					for (int i = lo, j = hi; j < shadow_count; i++, j++)
						shadow_store[i] = shadow_store[j];
					shadow_count -= hi - lo;
				end
			end
			rate_pkg::OP_FIND: begin
				if (lo > hi || hi > shadow_count) r.status = rate_pkg::ST_RANGE;
				else begin
					a = hi;
					while (a > lo && shadow_store[a-1] != key) a--;
					r.found_rank = 10'(a - 1);
				end
			end
			rate_pkg::OP_SEARCH: begin
				if (lo > hi || hi > shadow_count) r.status = rate_pkg::ST_RANGE;
				else begin
					a = lo;
					b = hi;
					while (a < b) begin
						m = (a + b) >> 1;
						if (key < shadow_store[m]) b = m;
						else a = m + 1;
					end
					r.found_rank = 10'(a - 1);
				end
			end
			rate_pkg::OP_INVCOUNT: begin
				for (int i = 1; i < shadow_count; i++)
					if (shadow_store[i-1] > shadow_store[i]) r.tally++;
			end
			rate_pkg::OP_COLLAPSE: begin
				if (shadow_count > 0) begin
					w = 0;
					for (int j = 1; j < shadow_count; j++)
						if (shadow_store[w] != shadow_store[j]) begin
							w++;
							shadow_store[w] = shadow_store[j];
						end
					w++;
					r.tally = 9'(shadow_count - w);
					shadow_count = w;
				end
			end
			default: r.status = rate_pkg::ST_RANGE;
		endcase
		r.count_after = 9'(shadow_count);
		return r;
	endfunction

	// drive one request word, predict it, optionally pin its result
	// called at a falling edge; valid stays up until the next word or idle gap
	task automatic send_request(input rate_pkg::op_t op, input int lo, input int hi,
			input logic [31:0] key, input logic has_fixed, input result_t fixed);
		result_t r;
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tdata  <= {3'b0, key, 9'(hi), 9'(lo), op};
		s_axis_tvalid <= 1;
		// ready only moves at rising edges, so check it between edges
		#1;
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		r = predict_store(op, lo, hi, key);
		if (has_fixed && r != fixed)
			$display("note: table row differs from shadow for op %s", op.name());
		pending_results.push_back(has_fixed ? fixed : r);
		@(negedge clk);
	endtask

	// receiver: random stall, compare each word with oldest prediction
	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[61:0];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata[31:0], 32'h0);
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status)
					report_mismatch("status", got.status, want.status);
				if (got.found_rank != want.found_rank)
					report_mismatch("found_rank", got.found_rank, want.found_rank);
				if (got.element_out != want.element_out)
					report_mismatch("element_out", got.element_out, want.element_out);
				if (got.tally != want.tally)
					report_mismatch("tally", got.tally, want.tally);
				if (got.count_after != want.count_after)
					report_mismatch("count_after", got.count_after, want.count_after);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL rank_array_table_engine");
			$finish;
		end
	end

	// random request, mostly legal ranges, biased toward a sorted store
	task automatic send_random_request();
		rate_pkg::op_t op;
		int lo, hi, pick;
		logic [31:0] key;
		pick = $urandom_range(99);
		if (pick < 35) op = rate_pkg::OP_INSERT;
		else if (pick < 45) op = rate_pkg::OP_READ;
		else if (pick < 55) op = rate_pkg::OP_REMOVE;
		else if (pick < 70) op = rate_pkg::OP_FIND;
		else if (pick < 88) op = rate_pkg::OP_SEARCH;
		else if (pick < 92) op = rate_pkg::OP_INVCOUNT;
		else if (pick < 96) op = rate_pkg::OP_COLLAPSE;
		else op = rate_pkg::op_t'($urandom_range(7));
		if ($urandom_range(9) == 0) begin
			lo = $urandom_range(511);
			hi = $urandom_range(511);
		end else begin
			lo = $urandom_range(shadow_count);
			hi = $urandom_range(shadow_count, lo);
			if (op == rate_pkg::OP_REMOVE && hi - lo > 4) hi = lo + $urandom_range(4);
		end
		if (op == rate_pkg::OP_READ && shadow_count > 0 && $urandom_range(3) != 0)
			lo = $urandom_range(shadow_count - 1);
		// small key pool gives duplicates and hits; sometimes full width
		key = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(15));
		if (op == rate_pkg::OP_INSERT && $urandom_range(1) == 0) begin
			// place near its sorted position to keep runs mostly ordered
			lo = 0;
			while (lo < shadow_count && shadow_store[lo] <= key) lo++;
		end
		send_request(op, lo, hi, key, 0, '0);
	endtask

	row_t    table_rows [$];
	result_t fx;

	initial begin
		row_t rw;
		send_gap_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		cycles = 0;
		shadow_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed table: pinned results on the empty store, errors and a first insert
		fx = '0; fx.status = rate_pkg::ST_RANGE;
		table_rows.push_back('{rate_pkg::OP_READ, 0, 0, 32'h0, 1, fx});
		fx = '0;
		table_rows.push_back('{rate_pkg::OP_COLLAPSE, 0, 0, 32'h0, 1, fx});
		table_rows.push_back('{rate_pkg::OP_INVCOUNT, 0, 0, 32'h0, 1, fx});
		table_rows.push_back('{rate_pkg::OP_REMOVE, 0, 0, 32'h0, 1, fx});
		fx = '0; fx.found_rank = 10'h3FF;
		table_rows.push_back('{rate_pkg::OP_FIND, 0, 0, 32'h5, 1, fx});
		table_rows.push_back('{rate_pkg::OP_SEARCH, 0, 0, 32'h5, 1, fx});
		fx = '0; fx.status = rate_pkg::ST_RANGE;
		table_rows.push_back('{rate_pkg::OP_INSERT, 1, 0, 32'h1, 1, fx});
		table_rows.push_back('{rate_pkg::OP_BAD, 0, 0, 32'h0, 1, fx});
		fx = '0; fx.count_after = 1;
		table_rows.push_back('{rate_pkg::OP_INSERT, 0, 0, 32'hFFFF_FFFF, 1, fx});
		// predictor-checked rows
		table_rows.push_back('{rate_pkg::OP_INSERT, 0, 0, 32'h0, 0, fx});
		table_rows.push_back('{rate_pkg::OP_INSERT, 2, 0, 32'h0, 0, fx});
		table_rows.push_back('{rate_pkg::OP_INSERT, 1, 0, 32'h7, 0, fx});
		table_rows.push_back('{rate_pkg::OP_READ, 3, 0, 32'h0, 0, fx});
		table_rows.push_back('{rate_pkg::OP_INVCOUNT, 0, 0, 32'h0, 0, fx});
		table_rows.push_back('{rate_pkg::OP_FIND, 0, 4, 32'h0, 0, fx});
		table_rows.push_back('{rate_pkg::OP_FIND, 1, 3, 32'hFFFF_FFFF, 0, fx});
		table_rows.push_back('{rate_pkg::OP_SEARCH, 0, 4, 32'h7, 0, fx});
		table_rows.push_back('{rate_pkg::OP_SEARCH, 3, 2, 32'h7, 0, fx});
		table_rows.push_back('{rate_pkg::OP_REMOVE, 0, 5, 32'h0, 0, fx});
		table_rows.push_back('{rate_pkg::OP_COLLAPSE, 0, 0, 32'h0, 0, fx});
		table_rows.push_back('{rate_pkg::OP_REMOVE, 1, 2, 32'h0, 0, fx});
		table_rows.push_back('{rate_pkg::OP_READ, 511, 0, 32'h0, 0, fx});
		table_rows.push_back('{rate_pkg::OP_FIND, 0, 511, 32'h0, 0, fx});
		foreach (table_rows[i]) begin
			rw = table_rows[i];
			send_request(rw.op, rw.lo, rw.hi, rw.key, rw.has_fixed, rw.fixed);
		end

		// fill to full, hit the full store, then drain
		while (shadow_count < DEPTH)
			send_request(rate_pkg::OP_INSERT, shadow_count, 0, 32'($urandom_range(40)), 0, '0);
		send_request(rate_pkg::OP_INSERT, 0, 0, 32'h1, 0, '0);
		send_request(rate_pkg::OP_INSERT, 300, 0, 32'h1, 0, '0);
		send_request(rate_pkg::OP_READ, 255, 0, 32'h0, 0, '0);
		send_request(rate_pkg::OP_SEARCH, 0, 256, 32'h14, 0, '0);
		send_request(rate_pkg::OP_FIND, 256, 256, 32'h0, 0, '0);
		send_request(rate_pkg::OP_INVCOUNT, 0, 0, 32'h0, 0, '0);
		send_request(rate_pkg::OP_REMOVE, 0, 256, 32'h0, 0, '0);

		// random traffic across idle phases
		for (int ph = 0; ph < 4; ph++) begin
			send_gap_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 9 : 53) : 0;
			stall_pct    = (ph == 2 || ph == 3) ? ((ph == 3) ? 9 : 53) : 0;
			for (int n = 0; n < N_RANDOM / 4; n++) send_random_request();
		end
		s_axis_tvalid <= 0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (mismatches == 0)
			$display("PASS rank_array_table_engine");
		else
			$display("FAIL rank_array_table_engine");
		$finish;
	end
endmodule
